// File: rtl/core/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Shared constants, codes and types of the pending-interest table engine.
// ----------------------------------------------------------------------------
package pit_pkg;

    localparam int TABLE_ENTRIES  = 64;
    localparam int MAX_REQUESTERS = 8;
    localparam int EMIT_LIMIT     = 8;

    localparam int SLOT_W     = $clog2(TABLE_ENTRIES);
    localparam int REQ_W      = $clog2(MAX_REQUESTERS);
    localparam int RCNT_W     = $clog2(MAX_REQUESTERS + 1);
    localparam int REQ_ADDR_W = SLOT_W + REQ_W;

    localparam int FUNC_W   = 3;
    localparam int KEY_W    = 64;
    localparam int PORT_W   = 16;
    localparam int TIME_W   = 48;
    localparam int HOP_W    = 8;
    localparam int IDX_W    = 6;
    localparam int MAXOUT_W = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CONSUME = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_EXPIRE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_COUNT   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] expiry;
        logic [HOP_W-1:0]  max_hop;
        logic [RCNT_W-1:0] req_count;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic ent_rd;
        logic ent_sel_scan;
        logic scan_eval;
        logic req_rd;
        logic agg_eval;
        logic cons_eval;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic agg_reqs;
        logic scan_last;
        logic req_match;
        logic agg_end;
        logic cons_emit;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/pit_if.sv
// ----------------------------------------------------------------------------
// pit_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface pit_in_if;
    logic                             valid;
    logic                             ready;
    logic [pit_pkg::FUNC_W-1:0]       func;
    logic [pit_pkg::KEY_W-1:0]        name_key;
    logic [pit_pkg::PORT_W-1:0]       req_face;
    logic [pit_pkg::TIME_W-1:0]       expire_time;
    logic [pit_pkg::TIME_W-1:0]       now_time;
    logic [pit_pkg::HOP_W-1:0]        hop_budget;
    logic [pit_pkg::IDX_W-1:0]        entry_index;
    logic [pit_pkg::MAXOUT_W-1:0]     max_out;

    modport source (output valid, func, name_key, req_face, expire_time, now_time,
                    hop_budget, entry_index, max_out, input ready);
    modport sink (input valid, func, name_key, req_face, expire_time, now_time,
                  hop_budget, entry_index, max_out, output ready);
endinterface

interface pit_out_if;
    logic                             valid;
    logic                             ready;
    logic [pit_pkg::STATUS_W-1:0]     status;
    logic [pit_pkg::IDX_W-1:0]        result_index;
    logic                             aggregated;
    logic                             retransmit;
    logic                             hop_raised;
    logic [pit_pkg::PORT_W-1:0]       port_out;
    logic [pit_pkg::COUNT_W-1:0]      count;
    logic                             last;

    modport source (output valid, status, result_index, aggregated, retransmit,
                    hop_raised, port_out, count, last, input ready);
    modport sink (input valid, status, result_index, aggregated, retransmit,
                  hop_raised, port_out, count, last, output ready);
endinterface

// File: rtl/core/pending_interest_table.sv
// Find and insert read and check the slots in turn and stop at the first live
// match; expire, count, a miss and a new insert scan all slots.
// An aggregating insert then reads and compares the stored requesters in turn, up to a match.
// Consume reads and checks the slot, then finishes or reads and emits each requester in turn.
// One item at a time: the next is taken after the previous one's last result is registered.
// Reset: all slots are marked free at once by their valid flops; no clearing pass is needed.
// ----------------------------------------------------------------------------
// pending_interest_table
// Pending-interest table engine: insert with aggregation, find, consume,
// expire sweep and occupancy count over a table of slots.
// ----------------------------------------------------------------------------
module pending_interest_table
(
    input  logic      clk,
    input  logic      rst_n,
    pit_in_if.sink    in_ch,
    pit_out_if.source out_ch
);

    // The controller sequences the scan of the slot memory and the walk over
    // the requester list; the datapath holds the memories and the result register.
    pit_pkg::cmd_t cmd;
    pit_pkg::sts_t sts;

    pit_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_func  (in_ch.func),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Results sit in an output register, so the next item is accepted while
    // the final result of the previous one still waits to be taken.
    pit_dpath u_dpath
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .sts                  (sts),
        .in_func              (in_ch.func),
        .in_name_key          (in_ch.name_key),
        .in_req_face          (in_ch.req_face),
        .in_expire_time       (in_ch.expire_time),
        .in_now_time          (in_ch.now_time),
        .in_hop_budget        (in_ch.hop_budget),
        .in_entry_index       (in_ch.entry_index),
        .in_max_out           (in_ch.max_out),
        .out_ready            (out_ch.ready),
        .out_valid            (out_ch.valid),
        .out_status           (out_ch.status),
        .out_result_index     (out_ch.result_index),
        .out_aggregated       (out_ch.aggregated),
        .out_retransmit       (out_ch.retransmit),
        .out_hop_raised       (out_ch.hop_raised),
        .out_port_out         (out_ch.port_out),
        .out_count            (out_ch.count),
        .out_last             (out_ch.last)
    );

endmodule

// File: rtl/core/pit_ctrl.sv
// ----------------------------------------------------------------------------
// pit_ctrl
// Sequencer that steps the datapath through scans, list walks and emits.
// ----------------------------------------------------------------------------
module pit_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [pit_pkg::FUNC_W-1:0] in_func,
    output logic                       in_ready,
    input  pit_pkg::sts_t              sts,
    output pit_pkg::cmd_t              cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_SCAN_RD  = 10'b0000000010,
        S_SCAN_CHK = 10'b0000000100,
        S_AGG_RD   = 10'b0000001000,
        S_AGG_CHK  = 10'b0000010000,
        S_FINISH   = 10'b0000100000,
        S_CONS_RD  = 10'b0001000000,
        S_CONS_CHK = 10'b0010000000,
        S_EMIT_RD  = 10'b0100000000,
        S_EMIT     = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    priority if (in_func == pit_pkg::FUNC_CONSUME)
                    begin
                        state_next = S_CONS_RD;
                    end
                    else if (in_func == pit_pkg::FUNC_INSERT || in_func == pit_pkg::FUNC_FIND ||
                             in_func == pit_pkg::FUNC_EXPIRE || in_func == pit_pkg::FUNC_COUNT)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN_RD:
            begin
                cmd.ent_rd       = 1'b1;
                cmd.ent_sel_scan = 1'b1;
                state_next       = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_eval = 1'b1;
                priority if (sts.hit && sts.agg_reqs)
                begin
                    state_next = S_AGG_RD;
                end
                else if (sts.hit || sts.scan_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_AGG_RD:
            begin
                cmd.req_rd = 1'b1;
                state_next = S_AGG_CHK;
            end
            S_AGG_CHK:
            begin
                cmd.agg_eval = 1'b1;
                state_next   = (sts.req_match || sts.agg_end) ? S_FINISH : S_AGG_RD;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CONS_RD:
            begin
                cmd.ent_rd = 1'b1;
                state_next = S_CONS_CHK;
            end
            S_CONS_CHK:
            begin
                cmd.cons_eval = 1'b1;
                state_next    = sts.cons_emit ? S_EMIT_RD : S_FINISH;
            end
            S_EMIT_RD:
            begin
                cmd.req_rd = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/pit_dpath.sv
// ----------------------------------------------------------------------------
// pit_dpath
// Slot memories, valid bits, scan counters and the result register.
// ----------------------------------------------------------------------------
module pit_dpath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  pit_pkg::cmd_t                cmd,
    output pit_pkg::sts_t                sts,
    input  logic [pit_pkg::FUNC_W-1:0]   in_func,
    input  logic [pit_pkg::KEY_W-1:0]    in_name_key,
    input  logic [pit_pkg::PORT_W-1:0]   in_req_face,
    input  logic [pit_pkg::TIME_W-1:0]   in_expire_time,
    input  logic [pit_pkg::TIME_W-1:0]   in_now_time,
    input  logic [pit_pkg::HOP_W-1:0]    in_hop_budget,
    input  logic [pit_pkg::IDX_W-1:0]    in_entry_index,
    input  logic [pit_pkg::MAXOUT_W-1:0] in_max_out,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [pit_pkg::STATUS_W-1:0] out_status,
    output logic [pit_pkg::IDX_W-1:0]    out_result_index,
    output logic                         out_aggregated,
    output logic                         out_retransmit,
    output logic                         out_hop_raised,
    output logic [pit_pkg::PORT_W-1:0]   out_port_out,
    output logic [pit_pkg::COUNT_W-1:0]  out_count,
    output logic                         out_last
);

    localparam int SW = pit_pkg::SLOT_W;

    pit_pkg::entry_t             ent_mem [pit_pkg::TABLE_ENTRIES];
    logic [pit_pkg::PORT_W-1:0]  req_mem [pit_pkg::TABLE_ENTRIES * pit_pkg::MAX_REQUESTERS];

    logic [pit_pkg::TABLE_ENTRIES-1:0] valid_reg;
    logic                              out_valid_reg;

    logic [pit_pkg::FUNC_W-1:0]   func_reg;
    logic [pit_pkg::KEY_W-1:0]    key_reg;
    logic [pit_pkg::PORT_W-1:0]   port_reg;
    logic [pit_pkg::TIME_W-1:0]   exp_reg;
    logic [pit_pkg::TIME_W-1:0]   now_reg;
    logic [pit_pkg::HOP_W-1:0]    hop_reg;
    logic [pit_pkg::IDX_W-1:0]    idx_reg;
    logic [pit_pkg::MAXOUT_W-1:0] max_out_reg;

    pit_pkg::entry_t              ent_q_reg;
    logic [pit_pkg::PORT_W-1:0]   req_q_reg;
    logic [SW-1:0]                scan_i_reg;
    logic [SW-1:0]                slot_reg;
    logic [SW-1:0]                free_idx_reg;
    logic                         free_found_reg;
    logic [pit_pkg::REQ_W-1:0]    j_reg;
    logic [pit_pkg::COUNT_W-1:0]  cnt_reg;
    logic [pit_pkg::MAXOUT_W-1:0] c_reg;
    logic                         wr_new_reg;
    logic                         wr_agg_reg;

    logic [pit_pkg::STATUS_W-1:0] res_status_reg;
    logic [pit_pkg::IDX_W-1:0]    res_idx_reg;
    logic                         res_agg_reg;
    logic                         res_rtx_reg;
    logic                         res_lhl_reg;
    logic [pit_pkg::COUNT_W-1:0]  res_count_reg;

    logic [pit_pkg::STATUS_W-1:0] out_status_reg;
    logic [pit_pkg::IDX_W-1:0]    out_idx_reg;
    logic                         out_agg_reg;
    logic                         out_rtx_reg;
    logic                         out_lhl_reg;
    logic [pit_pkg::PORT_W-1:0]   out_port_reg;
    logic [pit_pkg::COUNT_W-1:0]  out_count_reg;
    logic                         out_last_reg;

    logic                         is_ins;
    logic                         is_find;
    logic                         cur_v;
    logic                         key_match;
    logic                         expired;
    logic                         live_hit;
    logic                         stale;
    logic                         is_free_here;
    logic                         scan_clear;
    logic                         cnt_inc;
    logic                         free_any;
    logic [SW-1:0]                free_sel;
    logic                         cons_ok;
    logic [pit_pkg::RCNT_W-1:0]   n_req;
    logic [pit_pkg::MAXOUT_W-1:0] c1;
    logic [pit_pkg::MAXOUT_W-1:0] c_val;
    logic                         room;
    logic [SW-1:0]                ent_raddr;
    logic                         ent_we;
    pit_pkg::entry_t              ent_wdata;
    logic                         req_we;
    logic [pit_pkg::REQ_ADDR_W-1:0] req_waddr;
    logic [pit_pkg::COUNT_W-1:0]  cnt_sum;

    always_comb
    begin
        is_ins       = (func_reg == pit_pkg::FUNC_INSERT);
        is_find      = (func_reg == pit_pkg::FUNC_FIND);
        cur_v        = valid_reg[scan_i_reg];
        key_match    = (ent_q_reg.key == key_reg);
        expired      = (now_reg >= ent_q_reg.expiry);
        live_hit     = cur_v && key_match && !expired;
        stale        = cur_v && key_match && expired;
        is_free_here = !cur_v || stale;
        scan_clear   = (is_ins && stale) ||
                       ((func_reg == pit_pkg::FUNC_EXPIRE) && cur_v && expired);
        cnt_inc      = ((func_reg == pit_pkg::FUNC_EXPIRE) && cur_v && expired) ||
                       ((func_reg == pit_pkg::FUNC_COUNT) && cur_v);
        cnt_sum      = cnt_reg + pit_pkg::COUNT_W'(cnt_inc);
        free_any     = free_found_reg || is_free_here;
        free_sel     = free_found_reg ? free_idx_reg : scan_i_reg;
        n_req        = ent_q_reg.req_count;
        room         = (n_req < pit_pkg::RCNT_W'(pit_pkg::MAX_REQUESTERS));
        cons_ok      = (int'(idx_reg) < pit_pkg::TABLE_ENTRIES) && valid_reg[slot_reg];
        c1           = (pit_pkg::MAXOUT_W'(n_req) < max_out_reg) ?
                       pit_pkg::MAXOUT_W'(n_req) : max_out_reg;
        c_val        = (c1 > pit_pkg::MAXOUT_W'(pit_pkg::EMIT_LIMIT)) ?
                       pit_pkg::MAXOUT_W'(pit_pkg::EMIT_LIMIT) : c1;
        ent_raddr    = cmd.ent_sel_scan ? scan_i_reg : slot_reg;

        sts.hit       = (is_ins || is_find) && live_hit;
        sts.agg_reqs  = is_ins && (n_req != '0);
        sts.scan_last = (scan_i_reg == SW'(pit_pkg::TABLE_ENTRIES - 1));
        sts.req_match = (req_q_reg == port_reg);
        sts.agg_end   = ((pit_pkg::RCNT_W'(j_reg) + 1'b1) == n_req);
        sts.cons_emit = cons_ok && (max_out_reg != '0) && (c_val != '0);
        sts.emit_last = ((pit_pkg::MAXOUT_W'(j_reg) + 1'b1) == c_reg);
        sts.out_free  = !out_valid_reg || out_ready;

        // Slot writes happen as the final result leaves the sequencer.
        ent_we    = cmd.finish && (wr_new_reg || wr_agg_reg);
        req_we    = cmd.finish && (wr_new_reg || (wr_agg_reg && !res_rtx_reg && room));
        req_waddr = wr_new_reg ? {slot_reg, pit_pkg::REQ_W'(0)}
                               : {slot_reg, n_req[pit_pkg::REQ_W-1:0]};
        ent_wdata.key = key_reg;
        if (wr_new_reg)
        begin
            ent_wdata.expiry    = exp_reg;
            ent_wdata.max_hop   = hop_reg;
            ent_wdata.req_count = pit_pkg::RCNT_W'(1);
        end
        else
        begin
            ent_wdata.expiry    = (exp_reg > ent_q_reg.expiry) ? exp_reg : ent_q_reg.expiry;
            ent_wdata.max_hop   = (hop_reg > ent_q_reg.max_hop) ? hop_reg : ent_q_reg.max_hop;
            ent_wdata.req_count = (!res_rtx_reg && room) ? n_req + 1'b1 : n_req;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[slot_reg] <= ent_wdata;
        end
        if (cmd.ent_rd)
        begin
            ent_q_reg <= ent_mem[ent_raddr];
        end
        if (req_we)
        begin
            req_mem[req_waddr] <= port_reg;
        end
        if (cmd.req_rd)
        begin
            req_q_reg <= req_mem[{slot_reg, j_reg}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_eval && scan_clear)
            begin
                valid_reg[scan_i_reg] <= 1'b0;
            end
            if (cmd.cons_eval && cons_ok)
            begin
                valid_reg[slot_reg] <= 1'b0;
            end
            if (cmd.finish && wr_new_reg)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            if (cmd.finish || cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg       <= in_func;
            key_reg        <= in_name_key;
            port_reg       <= in_req_face;
            exp_reg        <= in_expire_time;
            now_reg        <= in_now_time;
            hop_reg        <= in_hop_budget;
            idx_reg        <= in_entry_index;
            max_out_reg    <= in_max_out;
            scan_i_reg     <= '0;
            slot_reg       <= SW'(in_entry_index);
            free_found_reg <= 1'b0;
            j_reg          <= '0;
            cnt_reg        <= '0;
            c_reg          <= '0;
            wr_new_reg     <= 1'b0;
            wr_agg_reg     <= 1'b0;
            res_status_reg <= pit_pkg::ST_BAD;
            res_idx_reg    <= '0;
            res_agg_reg    <= 1'b0;
            res_rtx_reg    <= 1'b0;
            res_lhl_reg    <= 1'b0;
            res_count_reg  <= '0;
        end

        if (cmd.scan_eval)
        begin
            if (cnt_inc)
            begin
                cnt_reg <= cnt_sum;
            end
            if (is_ins && is_free_here && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= scan_i_reg;
            end
            if (sts.hit)
            begin
                res_status_reg <= pit_pkg::ST_OK;
                res_idx_reg    <= pit_pkg::IDX_W'(scan_i_reg);
                slot_reg       <= scan_i_reg;
                if (is_ins)
                begin
                    res_agg_reg <= 1'b1;
                    res_lhl_reg <= (hop_reg > ent_q_reg.max_hop);
                    wr_agg_reg  <= 1'b1;
                end
            end
            else if (sts.scan_last)
            begin
                priority if (is_ins)
                begin
                    if (free_any)
                    begin
                        res_status_reg <= pit_pkg::ST_OK;
                        res_idx_reg    <= pit_pkg::IDX_W'(free_sel);
                        slot_reg       <= free_sel;
                        wr_new_reg     <= 1'b1;
                    end
                    else
                    begin
                        res_status_reg <= pit_pkg::ST_FULL;
                    end
                end
                else if (is_find)
                begin
                    res_status_reg <= pit_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    res_status_reg <= pit_pkg::ST_OK;
                    res_count_reg  <= cnt_sum;
                end
            end
            else
            begin
                scan_i_reg <= scan_i_reg + 1'b1;
            end
        end

        if (cmd.agg_eval)
        begin
            if (sts.req_match)
            begin
                res_rtx_reg <= 1'b1;
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
            end
        end

        if (cmd.cons_eval && cons_ok)
        begin
            res_status_reg <= pit_pkg::ST_OK;
            res_count_reg  <= (max_out_reg == '0) ? pit_pkg::COUNT_W'(n_req) : '0;
            c_reg          <= c_val;
        end

        if (cmd.emit)
        begin
            j_reg <= j_reg + 1'b1;
        end

        if (cmd.finish)
        begin
            out_status_reg <= res_status_reg;
            out_idx_reg    <= res_idx_reg;
            out_agg_reg    <= res_agg_reg;
            out_rtx_reg    <= res_rtx_reg;
            out_lhl_reg    <= res_lhl_reg;
            out_port_reg   <= '0;
            out_count_reg  <= res_count_reg;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit)
        begin
            out_status_reg <= pit_pkg::ST_OK;
            out_idx_reg    <= '0;
            out_agg_reg    <= 1'b0;
            out_rtx_reg    <= 1'b0;
            out_lhl_reg    <= 1'b0;
            out_port_reg   <= req_q_reg;
            out_count_reg  <= pit_pkg::COUNT_W'(c_reg);
            out_last_reg   <= sts.emit_last;
        end
    end

    assign out_valid            = out_valid_reg;
    assign out_status           = out_status_reg;
    assign out_result_index     = out_idx_reg;
    assign out_aggregated       = out_agg_reg;
    assign out_retransmit       = out_rtx_reg;
    assign out_hop_raised       = out_lhl_reg;
    assign out_port_out         = out_port_reg;
    assign out_count            = out_count_reg;
    assign out_last             = out_last_reg;

endmodule
